/* sv/stx_etx_frame_receiver_top_macros.svh */
// Assertion helpers for the frame receiver.
// Every macro expects signals named clk and rst_n in the calling scope.
`ifndef STX_ETX_FRAME_RECEIVER_TOP_MACROS_SVH
`define STX_ETX_FRAME_RECEIVER_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SEFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sefr_pkg.sv */
package sefr_pkg;

    // Default size of the payload store, in bytes.
    localparam int PayloadDepthDefault = 256;

    // Frame delimiters.
    localparam logic [7:0] StartByte = 8'h02;
    localparam logic [7:0] EndByte   = 8'h03;

    // Request function codes.
    localparam logic FuncPush = 1'b0;
    localparam logic FuncRead = 1'b1;

    // Result status codes.
    localparam logic [1:0] StatusNone = 2'd0;
    localparam logic [1:0] StatusOk   = 2'd1;
    localparam logic [1:0] StatusErr  = 2'd2;

    // Entries in the result queue ahead of the output.
    localparam int RspQueueDepth = 3;

    // Receiver phases.
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_LEN   = 3'd1,
        PH_DATA  = 3'd2,
        PH_CHK   = 3'd3,
        PH_END   = 3'd4
    } phase_t;

    // One request on the input channel.
    typedef struct packed {
        logic       func;
        logic [7:0] byte_in;
        logic [7:0] read_index;
    } req_t;

    // One result on the output channel.
    typedef struct packed {
        logic [1:0] status;
        logic       frame_ready;
        logic [7:0] payload_length;
        logic [7:0] read_data;
    } rsp_t;

    // Frame state as seen after one request.
    typedef struct packed {
        logic [1:0] status;
        logic       frame_ready;
        logic [7:0] payload_length;
    } frame_info_t;

    // Write port request into the payload store.
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } mem_wr_t;

endpackage

/* sv/sefr_frame_ctrl.sv */
module sefr_frame_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            push_byte,
    output sefr_pkg::frame_info_t info,
    output sefr_pkg::mem_wr_t     mem_wr
);
    import sefr_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] chk_reg, chk_next;
    logic [7:0] sum_reg, sum_next;
    logic       ready_reg, ready_next;
    logic [1:0] status;

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            chk_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            ready_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            chk_reg   <= chk_next;
            sum_reg   <= sum_next;
            ready_reg <= ready_next;
        end
    end

    // Next state, status and the store write for one pushed byte.
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        chk_next    = chk_reg;
        sum_next    = sum_reg;
        ready_next  = ready_reg;
        status      = StatusNone;
        mem_wr.en   = 1'b0;
        mem_wr.addr = count_reg;
        mem_wr.data = push_byte;
        if (push)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    // A zero length aborts the frame.
                    if (push_byte != 8'd0)
                    begin
                        len_next   = push_byte;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_DATA:
                begin
                    mem_wr.en  = 1'b1;
                    sum_next   = sum_reg + push_byte;
                    count_next = count_reg + 8'd1;
                    if (count_next >= len_reg)
                    begin
                        phase_next = PH_CHK;
                    end
                end
                PH_CHK:
                begin
                    chk_next   = push_byte;
                    phase_next = PH_END;
                end
                PH_END:
                begin
                    if (push_byte == EndByte && sum_reg == chk_reg)
                    begin
                        ready_next = 1'b1;
                        status     = StatusOk;
                    end
                    else
                    begin
                        status = StatusErr;
                    end
                    phase_next = PH_START;
                end
                default:
                begin
                    // Start search: a start byte opens a new frame.
                    if (push_byte == StartByte)
                    begin
                        phase_next = PH_LEN;
                        count_next = 8'd0;
                        sum_next   = 8'd0;
                        ready_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
            endcase
        end
        info.status         = status;
        info.frame_ready    = ready_next;
        info.payload_length = len_next;
    end

endmodule

/* sv/sefr_payload_mem.sv */
module sefr_payload_mem #(
    parameter int PAYLOAD_DEPTH = sefr_pkg::PayloadDepthDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sefr_pkg::mem_wr_t mem_wr,
    input  logic              rd_en,
    input  logic [7:0]        rd_addr,
    output logic [7:0]        rd_data
);
    import sefr_pkg::*;

    localparam int         AddrW  = $clog2(PAYLOAD_DEPTH);
    localparam logic [8:0] DepthW = 9'(PAYLOAD_DEPTH);

    logic [7:0]               mem [PAYLOAD_DEPTH];
    logic [PAYLOAD_DEPTH-1:0] valid_reg;
    logic [7:0]               rd_word_reg;
    logic                     rd_hit_reg;
    logic                     wr_hit;
    logic                     rd_hit;

    // Positions beyond the store are neither written nor read.
    assign wr_hit = mem_wr.en && ({1'b0, mem_wr.addr} < DepthW);
    assign rd_hit = rd_en && ({1'b0, rd_addr} < DepthW);

    // Storage array with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[mem_wr.addr[AddrW-1:0]] <= mem_wr.data;
        end
        if (rd_hit)
        begin
            rd_word_reg <= mem[rd_addr[AddrW-1:0]];
        end
    end

    // Written-entry flags; an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg[mem_wr.addr[AddrW-1:0]] <= 1'b1;
            end
            rd_hit_reg <= rd_hit && valid_reg[rd_addr[AddrW-1:0]];
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : 8'd0;

endmodule

/* sv/sefr_rsp_fifo.sv */
module sefr_rsp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sefr_pkg::rsp_t push_data,
    input  logic           pop,
    output logic           out_valid,
    output sefr_pkg::rsp_t out_data,
    output logic [1:0]     count
);
    import sefr_pkg::*;

    localparam logic [1:0] LastPtr = 2'(RspQueueDepth - 1);

    rsp_t       entry_reg [RspQueueDepth];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? 2'd0 : wr_ptr_reg + 2'd1;
            count_next  = count_next + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? 2'd0 : rd_ptr_reg + 2'd1;
            count_next  = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

/* sv/stx_etx_frame_receiver_top.sv */
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_stall | req_data (func, byte_in, read_index)
// rsp     | out       | rsp_valid / rsp_stall | rsp_data (status, frame_ready,
//         |           |                       |           payload_length, read_data)
//
// One request is taken every cycle while req_stall is low; its result is registered
// in the payload store's registered read port and the read stage, then in the result queue.
// Reset clears the frame state and the per-entry written flags of the store at once,
// so requests are taken from the first cycle after reset.
// A three-entry result queue absorbs output stalls; req_stall rises only when the
// queue and the read stage together hold three results.
module stx_etx_frame_receiver_top #(
    parameter int PAYLOAD_DEPTH = sefr_pkg::PayloadDepthDefault
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sefr_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sefr_pkg::rsp_t rsp_data
);
    import sefr_pkg::*;

    logic        accept;
    logic        push;
    logic        rd_en;
    frame_info_t info;
    mem_wr_t     mem_wr;
    logic [7:0]  rd_data;
    logic        s1_valid_reg;
    frame_info_t s1_info_reg;
    rsp_t        q_push_data;
    logic        q_pop;
    logic [1:0]  q_count;

    // Request acceptance and decode.
    assign accept = req_valid && !req_stall;
    assign push   = accept && (req_data.func == FuncPush);
    assign rd_en  = accept && (req_data.func == FuncRead);

    sefr_frame_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_byte (req_data.byte_in),
        .info      (info),
        .mem_wr    (mem_wr)
    );

    sefr_payload_mem #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_wr  (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (req_data.read_index),
        .rd_data (rd_data)
    );

    // Read stage: frame state waits here alongside the store read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
    end

    // Assemble the result and queue it.
    always_comb
    begin
        q_push_data.status         = s1_info_reg.status;
        q_push_data.frame_ready    = s1_info_reg.frame_ready;
        q_push_data.payload_length = s1_info_reg.payload_length;
        q_push_data.read_data      = rd_data;
    end

    assign q_pop = rsp_valid && !rsp_stall;

    sefr_rsp_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (q_push_data),
        .pop       (q_pop),
        .out_valid (rsp_valid),
        .out_data  (rsp_data),
        .count     (q_count)
    );

    // Hold off requests once every queue slot is spoken for.
    assign req_stall = ((q_count + {1'b0, s1_valid_reg}) == 2'(RspQueueDepth));

endmodule

/* sv/sefr_port_chk.sv */
`include "stx_etx_frame_receiver_top_macros.svh"

module sefr_port_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input sefr_pkg::rsp_t rsp_data
);
    import sefr_pkg::*;

    logic rsp_held;
    logic ok_seen;
    logic ok_fields;
    logic err_seen;
    logic frame_seen;

    // Shorthand for the result conditions checked below.
    assign rsp_held   = rsp_valid && rsp_stall;
    assign ok_seen    = rsp_valid && (rsp_data.status == StatusOk);
    assign ok_fields  = rsp_data.frame_ready && (rsp_data.payload_length != 8'd0);
    assign err_seen   = rsp_valid && (rsp_data.status == StatusErr);
    assign frame_seen = rsp_valid && (rsp_data.status != StatusNone);

    // A stalled result stays offered and unchanged.
    `SEFR_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data), "held result changed")

    // An accepted frame raises the ready flag and carries a nonzero length.
    `SEFR_ASSERT(a_ok_ready, !ok_seen || ok_fields, "accepted frame without ready flag or length")

    // A failed frame never shows the ready flag, which its start byte cleared.
    `SEFR_ASSERT(a_err_not_ready, !err_seen || !rsp_data.frame_ready, "frame error with ready set")

    // A frame result never returns store data.
    `SEFR_ASSERT(a_frame_no_data, !frame_seen || rsp_data.read_data == 8'd0, "frame result with data")

endmodule

bind stx_etx_frame_receiver_top sefr_port_chk u_port_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
